// ----- hdl/agi_pkg.sv -----
// Package for the anagram group indexer: sizes, command and status codes,
// sequencer state type. No dependencies.
`default_nettype none

package agi_pkg;

  localparam int MaxWordLen   = 15;
  localparam int GroupEntries = 16;
  localparam int AlphabetSize = 26;

  localparam int CountW   = 4;
  localparam int LenW     = 4;
  localparam int IdxOutW  = 4;
  localparam int SigW     = AlphabetSize * CountW;
  localparam int AddrW    = (GroupEntries > 1) ? $clog2(GroupEntries) : 1;
  localparam int UsedW    = $clog2(GroupEntries + 1);
  localparam int LetterW  = 8;
  localparam int CmdW     = 2;
  localparam int LaneW    = $clog2(AlphabetSize);

  localparam logic [LetterW-1:0] CharLowA = 8'h61;
  localparam logic [LetterW-1:0] CharLowZ = 8'h7a;

  typedef enum logic [CmdW-1:0] {
    CmdLetter = 2'd0,
    CmdEmpty  = 2'd1,
    CmdClear  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBadChar = 2'd1,
    StatTooLong = 2'd2,
    StatFull    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StLook = 4'b0010,
    StCmp  = 4'b0100,
    StDone = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/anagram_group_indexer.sv -----
// Anagram group indexer top level: letter counting, group table, search sequencer.
// Depends on agi_pkg.
`default_nettype none

// Letters are taken one per cycle while a word is collected. At the word end the
// stored group signatures are read from the table one entry at a time (table
// read in StLook, then a 104-bit compare on the single comparator in StCmp), up
// to G entries, G being the number of groups already stored, and no new item is
// taken until the search ends; a rejected word skips the search. The result sits
// in an output register until it is taken, and a further word end waits on it.
// Clear and unused commands are handled in StIdle without leaving it.
module anagram_group_indexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // cmd[1:0], letter[9:2], zero fill
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // group_index[3:0], is_new_group[4],
                                          // word_length[8:5], status[10:9], zero fill
);

  agi_pkg::state_e state_q, state_d;

  logic [agi_pkg::CountW-1:0] cnt_q [agi_pkg::AlphabetSize];
  logic [agi_pkg::CountW-1:0] cnt_d [agi_pkg::AlphabetSize];
  logic [agi_pkg::LenW-1:0]   len_q, len_d;
  logic                       bad_q, bad_d;
  logic                       long_q, long_d;
  logic [agi_pkg::UsedW-1:0]  used_q, used_d;
  logic [agi_pkg::UsedW-1:0]  idx_q, idx_d;

  logic [agi_pkg::SigW-1:0]   mem_q [agi_pkg::GroupEntries];
  logic [agi_pkg::SigW-1:0]   rd_q;
  logic                       mem_we;
  logic [agi_pkg::SigW-1:0]   sig;

  logic [agi_pkg::IdxOutW-1:0] res_idx_q, res_idx_d;
  logic                        res_new_q, res_new_d;
  agi_pkg::status_e            res_stat_q, res_stat_d;

  logic                        out_vld_q, out_vld_d;
  logic [15:0]                 out_data_q, out_data_d;

  logic                        in_acc;
  agi_pkg::cmd_e               cmd;
  logic [agi_pkg::LetterW-1:0] letter;
  logic                        char_ok;
  logic [agi_pkg::LaneW-1:0]   lane;
  logic                        out_free;
  logic [agi_pkg::LetterW-1:0] lane_off;

  assign cmd      = agi_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign letter   = s_axis_tdata[9:2];
  assign char_ok  = (letter >= agi_pkg::CharLowA) && (letter <= agi_pkg::CharLowZ);
  assign lane_off = letter - agi_pkg::CharLowA;
  assign lane     = lane_off[agi_pkg::LaneW-1:0];
  assign s_axis_tready = (state_q == agi_pkg::StIdle);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    for (int i = 0; i < agi_pkg::AlphabetSize; i++) begin
      sig[i*agi_pkg::CountW +: agi_pkg::CountW] = cnt_q[i];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    bad_d      = bad_q;
    long_d     = long_q;
    used_d     = used_q;
    idx_d      = idx_q;
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_stat_d = res_stat_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    mem_we     = 1'b0;

    unique case (state_q)
      agi_pkg::StIdle: begin
        if (in_acc) begin
          idx_d = '0;
          case (cmd)
            agi_pkg::CmdLetter: begin
              if (!char_ok) begin
                bad_d = 1'b1;
              end else if (len_q >= agi_pkg::LenW'(agi_pkg::MaxWordLen)) begin
                long_d = 1'b1;
              end else begin
                for (int i = 0; i < agi_pkg::AlphabetSize; i++) begin
                  if (lane == agi_pkg::LaneW'(i)) begin
                    cnt_d[i] = cnt_q[i] + 1'b1;
                  end
                end
                len_d = len_q + 1'b1;
              end
              if (s_axis_tlast) begin
                state_d = agi_pkg::StLook;
              end
            end
            agi_pkg::CmdEmpty: begin
              state_d = agi_pkg::StLook;
            end
            agi_pkg::CmdClear: begin
              for (int i = 0; i < agi_pkg::AlphabetSize; i++) begin
                cnt_d[i] = '0;
              end
              len_d  = '0;
              bad_d  = 1'b0;
              long_d = 1'b0;
              used_d = '0;
            end
            default: ;
          endcase
        end
      end
      agi_pkg::StLook: begin
        res_idx_d  = '0;
        res_new_d  = 1'b0;
        res_stat_d = agi_pkg::StatOk;
        if (bad_q) begin
          res_stat_d = agi_pkg::StatBadChar;
          state_d    = agi_pkg::StDone;
        end else if (long_q) begin
          res_stat_d = agi_pkg::StatTooLong;
          state_d    = agi_pkg::StDone;
        end else if (idx_q == used_q) begin
          if (used_q == agi_pkg::UsedW'(agi_pkg::GroupEntries)) begin
            res_stat_d = agi_pkg::StatFull;
          end else begin
            mem_we    = 1'b1;
            res_idx_d = agi_pkg::IdxOutW'(used_q);
            res_new_d = 1'b1;
            used_d    = used_q + 1'b1;
          end
          state_d = agi_pkg::StDone;
        end else begin
          state_d = agi_pkg::StCmp;
        end
      end
      agi_pkg::StCmp: begin
        if (rd_q == sig) begin
          res_idx_d = agi_pkg::IdxOutW'(idx_q);
          state_d   = agi_pkg::StDone;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = agi_pkg::StLook;
        end
      end
      agi_pkg::StDone: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {5'd0, res_stat_q, len_q, res_new_q, res_idx_q};
          for (int i = 0; i < agi_pkg::AlphabetSize; i++) begin
            cnt_d[i] = '0;
          end
          len_d   = '0;
          bad_d   = 1'b0;
          long_d  = 1'b0;
          state_d = agi_pkg::StIdle;
        end
      end
      default: state_d = agi_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= agi_pkg::StIdle;
      len_q     <= '0;
      bad_q     <= 1'b0;
      long_q    <= 1'b0;
      used_q    <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < agi_pkg::AlphabetSize; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      bad_q     <= bad_d;
      long_q    <= long_d;
      used_q    <= used_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_stat_q <= res_stat_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[used_q[agi_pkg::AddrW-1:0]] <= sig;
    end
    rd_q <= mem_q[idx_q[agi_pkg::AddrW-1:0]];
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= agi_pkg::UsedW'(agi_pkg::GroupEntries))
    else $error("group count beyond table size");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == agi_pkg::StCmp) |-> (idx_q < used_q))
    else $error("compare on an unused table entry");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> (sig == '0))
    else $error("letter counts set with zero length");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_data_q[10:9] != agi_pkg::StatOk)) |-> (out_data_q[4:0] == '0))
    else $error("rejected word carries a group index");

endmodule

`default_nettype wire
